>>> hw/rtl/b64e_pkg.sv
// Shared types, constants and the sextet-to-ASCII mapping of the Base64 encoder.
package b64e_pkg;

  localparam int QUEUE_DEPTH = 4;

  localparam logic [6:0] ASCII_UPPER_A = 7'h41;
  localparam logic [6:0] ASCII_LOWER_A = 7'h61;
  localparam logic [6:0] ASCII_DIGIT_0 = 7'h30;
  localparam logic [6:0] ASCII_PLUS    = 7'h2B;
  localparam logic [6:0] ASCII_SLASH   = 7'h2F;

  localparam logic [5:0] SEXTET_LOWER  = 6'd26;
  localparam logic [5:0] SEXTET_DIGIT  = 6'd52;
  localparam logic [5:0] SEXTET_PLUS   = 6'd62;

  // Position of the next byte inside its 3-byte group.
  typedef enum logic [1:0] {
    PH_FIRST  = 2'd0,
    PH_SECOND = 2'd1,
    PH_THIRD  = 2'd2
  } phase_t;

  // One encoded byte: one or two sextets waiting for the back end.
  typedef struct packed {
    logic [5:0] sextet0;
    logic [5:0] sextet1;
    logic       pair;
    logic       fin;
  } group_entry_t;

  typedef struct packed {
    phase_t phase;
  } front_stat_t;

  function automatic logic [6:0] sextet_char(input logic [5:0] s);
    logic [6:0] c;
    if (s < SEXTET_LOWER) begin
      c = ASCII_UPPER_A + {1'b0, s};
    end else if (s < SEXTET_DIGIT) begin
      c = ASCII_LOWER_A + {1'b0, s} - {1'b0, SEXTET_LOWER};
    end else if (s < SEXTET_PLUS) begin
      c = ASCII_DIGIT_0 + {1'b0, s} - {1'b0, SEXTET_DIGIT};
    end else if (s == SEXTET_PLUS) begin
      c = ASCII_PLUS;
    end else begin
      c = ASCII_SLASH;
    end
    return c;
  endfunction

endpackage

>>> hw/rtl/b64e_if.sv
// Valid/ready channel interfaces for raw bytes in and Base64 characters out.
interface b64e_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface b64e_out_if;
  logic       valid;
  logic       ready;
  logic [6:0] out_char;
  logic       last_char;

  modport source (output valid, output out_char, output last_char, input ready);
  modport sink   (input valid, input out_char, input last_char, output ready);
endinterface

>>> hw/rtl/b64e_front.sv
// Front end: takes bytes, tracks group phase and carry, builds sextet entries.
module b64e_front
  import b64e_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  b64e_in_if.sink       in_ch,
  input  logic          q_full,
  output logic          q_push,
  output group_entry_t  q_entry,
  output front_stat_t   stat
);

  phase_t     phase, phase_next;
  logic [3:0] carry, carry_next;
  logic [7:0] b;
  logic       last;

  assign b           = in_ch.data_byte;
  assign last        = in_ch.last_byte;
  assign in_ch.ready = !q_full;
  assign q_push      = in_ch.valid && !q_full;
  assign stat.phase  = phase;

  always_comb begin
    q_entry.pair = last;
    q_entry.fin  = last;
    case (phase)
      PH_SECOND: begin
        q_entry.sextet0 = {carry[1:0], b[7:4]};
        q_entry.sextet1 = {b[3:0], 2'b00};
        carry_next      = b[3:0];
        phase_next      = PH_THIRD;
      end
      PH_THIRD: begin
        q_entry.sextet0 = {carry, b[7:6]};
        q_entry.sextet1 = b[5:0];
        q_entry.pair    = 1'b1;
        carry_next      = 4'd0;
        phase_next      = PH_FIRST;
      end
      default: begin
        q_entry.sextet0 = b[7:2];
        q_entry.sextet1 = {b[1:0], 4'b0000};
        carry_next      = {2'b00, b[1:0]};
        phase_next      = PH_SECOND;
      end
    endcase
    if (last) begin
      carry_next = 4'd0;
      phase_next = PH_FIRST;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_FIRST;
      carry <= 4'd0;
    end else if (q_push) begin
      phase <= phase_next;
      carry <= carry_next;
    end
  end

endmodule

>>> hw/rtl/b64e_queue.sv
// Small FIFO of sextet entries between the front and back ends.
module b64e_queue
  import b64e_pkg::*;
#(
  parameter int Depth = QUEUE_DEPTH
)
(
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       push,
  input  group_entry_t               push_entry,
  output logic                       full,
  input  logic                       pop,
  output group_entry_t               pop_entry,
  output logic                       empty,
  output logic [$clog2(Depth+1)-1:0] level
);

  localparam int PtrW = $clog2(Depth);
  localparam int LvlW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastSlot = PtrW'(Depth - 1);
  localparam logic [LvlW-1:0] FullLvl  = LvlW'(Depth);

  group_entry_t    slots [Depth];
  logic [PtrW-1:0] wr_ptr, rd_ptr;
  logic            do_push, do_pop;

  assign full      = (level == FullLvl);
  assign empty     = (level == '0);
  assign do_push   = push && !full;
  assign do_pop    = pop && !empty;
  assign pop_entry = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      level  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == LastSlot) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == LastSlot) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        level <= level + 1'b1;
      end else if (do_pop && !do_push) begin
        level <= level - 1'b1;
      end
    end
  end

endmodule

>>> hw/rtl/b64e_back.sv
// Back end: queued entries to output register, one character per cycle when not stalled.
module b64e_back
  import b64e_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  input  group_entry_t  q_entry,
  input  logic          q_empty,
  output logic          q_pop,
  b64e_out_if.source    out_ch
);

  logic       sel;
  logic       load;
  logic       take_second;
  logic [5:0] sextet;

  assign load        = !out_ch.valid || out_ch.ready;
  assign take_second = q_entry.pair && !sel;
  assign q_pop       = load && !q_empty && !take_second;
  assign sextet      = sel ? q_entry.sextet1 : q_entry.sextet0;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_ch.valid <= 1'b0;
      sel          <= 1'b0;
    end else if (load) begin
      out_ch.valid <= !q_empty;
      if (!q_empty) begin
        sel <= take_second;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load && !q_empty) begin
      out_ch.out_char  <= sextet_char(sextet);
      out_ch.last_char <= q_entry.fin && (sel || !q_entry.pair);
    end
  end

endmodule

>>> hw/rtl/base64_encoder_no_padding_core.sv
// Top level of the streaming Base64 encoder without padding.
//
//   channel  | dir | payload                     | notes
//   ---------+-----+-----------------------------+------------------------------
//   in_ch    | in  | data_byte[7:0], last_byte   | one raw byte per request
//   out_ch   | out | out_char[6:0], last_char    | one ASCII character per request
//
// Rate: the back end issues one character per cycle while out_ch is not
// stalled; a byte that yields two characters (third byte of a group, or any
// last byte) holds its queue entry until both are sent, and single-character
// bytes run at one per cycle. An input request reaches output valid through
// the queue write, then the output register.
// Reset (rst, synchronous) clears group phase, carry, queue pointers and
// output valid. The front takes a new request whenever the queue has room,
// so an output stall only blocks input once QueueDepth entries are waiting.
module base64_encoder_no_padding_core
  import b64e_pkg::*;
#(
  parameter int QueueDepth = QUEUE_DEPTH
)
(
  input  logic        clk,
  input  logic        rst,
  b64e_in_if.sink     in_ch,
  b64e_out_if.source  out_ch
);

  localparam int LvlW = $clog2(QueueDepth + 1);

  // front -> queue
  logic         q_push;
  group_entry_t q_push_entry;
  logic         q_full;
  front_stat_t  front_stat;

  // queue -> back
  logic         q_pop;
  group_entry_t q_head;
  logic         q_empty;
  logic [LvlW-1:0] q_level;

  // Front end: phase/carry tracking and sextet extraction.
  b64e_front u_front (
    .clk     (clk),
    .rst     (rst),
    .in_ch   (in_ch),
    .q_full  (q_full),
    .q_push  (q_push),
    .q_entry (q_push_entry),
    .stat    (front_stat)
  );

  // Decoupling queue; each entry holds the sextets of one byte.
  b64e_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_entry (q_push_entry),
    .full       (q_full),
    .pop        (q_pop),
    .pop_entry  (q_head),
    .empty      (q_empty),
    .level      (q_level)
  );

  // Back end: alphabet lookup and output register.
  b64e_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_entry (q_head),
    .q_empty (q_empty),
    .q_pop   (q_pop),
    .out_ch  (out_ch)
  );

`ifndef SYNTHESIS
  // Queue occupancy never exceeds its depth.
  assert property (@(posedge clk) disable iff (rst) q_level <= LvlW'(QueueDepth))
    else $error("queue level above depth");

  // Input is ready exactly when the queue has room.
  assert property (@(posedge clk) disable iff (rst)
    in_ch.ready == (q_level != LvlW'(QueueDepth)))
    else $error("input ready does not track queue room");

  // A last byte always closes the group.
  assert property (@(posedge clk) disable iff (rst)
    (in_ch.valid && in_ch.ready && in_ch.last_byte) |=> front_stat.phase == PH_FIRST)
    else $error("phase not reset after last byte");

  // A non-last first byte of a group advances to the second position.
  assert property (@(posedge clk) disable iff (rst)
    (in_ch.valid && in_ch.ready && !in_ch.last_byte && front_stat.phase == PH_FIRST)
      |=> front_stat.phase == PH_SECOND)
    else $error("phase did not advance after first byte");
`endif

endmodule

>>> test/b64e_tb_pkg.sv
// Scoreboard that predicts and checks the Base64 character stream.
package b64e_tb_pkg;
  import b64e_pkg::*;

  localparam string B64_ALPHABET =
    "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

  typedef struct packed {
    logic [6:0] code;
    logic       fin;
  } b64_char_t;

  class b64_char_tracker;
    phase_t    phase;
    logic [3:0] carry;
    b64_char_t pending_chars[$];
    int        errors;

    function new();
      phase  = PH_FIRST;
      carry  = '0;
      errors = 0;
    endfunction

    function void push_sextet(input logic [5:0] s, input logic fin);
      b64_char_t c;
      c.code = 7'(B64_ALPHABET[s]);
      c.fin  = fin;
      pending_chars.push_back(c);
    endfunction

    // Accepted byte: work out the one or two characters it produces.
    function void note_byte(input logic [7:0] b, input logic last);
      case (phase)
        PH_SECOND: begin
          push_sextet({carry[1:0], b[7:4]}, 1'b0);
          carry = b[3:0];
          phase = PH_THIRD;
          if (last) push_sextet({b[3:0], 2'b00}, 1'b1);
        end
        PH_THIRD: begin
          push_sextet({carry, b[7:6]}, 1'b0);
          push_sextet(b[5:0], last);
          phase = PH_FIRST;
          carry = '0;
        end
        default: begin
          push_sextet(b[7:2], 1'b0);
          carry = {2'b00, b[1:0]};
          phase = PH_SECOND;
          if (last) push_sextet({b[1:0], 4'b0000}, 1'b1);
        end
      endcase
      if (last) begin
        phase = PH_FIRST;
        carry = '0;
      end
    endfunction

    function void check_char(input logic [6:0] code, input logic fin, input realtime t);
      b64_char_t exp_c;
      if (pending_chars.size() == 0) begin
        errors++;
        $display("%0t: unexpected char 0x%02h last=%0b", t, code, fin);
        return;
      end
      exp_c = pending_chars.pop_front();
      if (code !== exp_c.code) begin
        errors++;
        $display("%0t: out_char expected 0x%02h actual 0x%02h", t, exp_c.code, code);
      end
      if (fin !== exp_c.fin) begin
        errors++;
        $display("%0t: last_char expected %0b actual %0b", t, exp_c.fin, fin);
      end
    endfunction

    function int pending();
      return pending_chars.size();
    endfunction
  endclass

endpackage

>>> test/base64_encoder_no_padding_core_tb.sv
// Testbench for the streaming Base64 encoder: random bursts, stalls, scoreboard check.
module base64_encoder_no_padding_core_tb
  import b64e_tb_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int NUM_BYTES   = 1200;
  localparam int CYCLE_LIMIT = 400000;

  logic clk;
  logic rst;

  b64e_in_if  in_ch();
  b64e_out_if out_ch();

  base64_encoder_no_padding_core dut (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  b64_char_tracker tracker;

  int  bytes_sent;     // accepted input requests
  int  burst_left;     // requests left in the current sender burst
  bit  flood;          // sender ignores its gaps while set
  int  receiver_hold;  // cycles the receiver still refuses output
  int  cycle_cnt;

  // 20 ns clock
  initial clk = 1'b0;
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Watchdog: a hung handshake ends the run here.
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // Receiver: picks a new mode whenever mode_left runs out, among always ready,
  // coin flip and mostly stalled. A pending hold request overrides the mode and
  // is counted down here, once per falling edge.
  initial begin : receiver
    int mode;
    int mode_left;
    out_ch.ready = 1'b0;
    mode      = 0;
    mode_left = 0;
    forever begin
      @(negedge clk);
      if (mode_left == 0) begin
        mode      = $urandom_range(0, 2);
        mode_left = 64;
      end
      mode_left--;
      if (rst) begin
        out_ch.ready <= 1'b0;
      end else if (receiver_hold > 0) begin
        receiver_hold--;
        out_ch.ready <= 1'b0;
      end else begin
        case (mode)
          0:       out_ch.ready <= 1'b1;
          1:       out_ch.ready <= $urandom_range(0, 1);
          default: out_ch.ready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  // Output monitor: every accepted character goes against the oldest prediction.
  always @(posedge clk) begin
    if (!rst && out_ch.valid && out_ch.ready) begin
      tracker.check_char(out_ch.out_char, out_ch.last_char, $realtime);
    end
  end

  // Offer one byte and hold it until accepted. Called and returns at a falling
  // edge. Gaps are inserted only between bursts; valid drops just for a gap.
  task automatic send_byte(input logic [7:0] b, input logic last);
    int gap;
    if (burst_left == 0) begin
      gap = flood ? 0 : $urandom_range(0, 6);
      if (gap > 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      // Occasional long bursts give stretches with no idling on the input.
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60)
                                               : $urandom_range(1, 8);
    end
    in_ch.valid     <= 1'b1;
    in_ch.data_byte <= b;
    in_ch.last_byte <= last;
    do @(posedge clk); while (!in_ch.ready);
    tracker.note_byte(b, last);
    bytes_sent++;
    burst_left--;
    @(negedge clk);
  endtask

  // Pause the sender until every predicted character has been taken.
  task automatic drain_outputs();
    in_ch.valid <= 1'b0;
    burst_left = 0;
    while (tracker.pending() != 0) @(negedge clk);
  endtask

  // Block the receiver for a long stretch while pushing a full message
  // back to back, so the internal queue fills and input ready drops.
  task automatic flood_while_blocked();
    receiver_hold = 120;
    flood         = 1'b1;
    for (int i = 0; i < 24; i++) begin
      send_byte(8'($urandom), i == 23);
    end
    flood = 1'b0;
  endtask

  initial begin : stimulus
    int         len;
    int         msg_cnt;
    logic [7:0] b;

    tracker          = new();
    bytes_sent       = 0;
    burst_left       = 0;
    flood            = 1'b0;
    receiver_hold    = 0;
    cycle_cnt        = 0;
    msg_cnt          = 0;
    rst              = 1'b1;
    in_ch.valid      = 1'b0;
    in_ch.data_byte  = '0;
    in_ch.last_byte  = 1'b0;

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed: one-byte messages end in the first phase, two-byte in the
    // second, three-byte in the third; all-zero and all-one data reach the
    // lowest and highest sextets, and 0xFB 0xEF 0xBE gives the '+' sextet.
    send_byte(8'h00, 1'b1);
    send_byte(8'hFF, 1'b1);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h00, 1'b1);
    send_byte(8'hFF, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'hFF, 1'b1);
    send_byte(8'hFB, 1'b0);
    send_byte(8'hEF, 1'b0);
    send_byte(8'hBE, 1'b1);
    send_byte(8'h00, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h00, 1'b1);
    // Four-byte message wraps into a second group before the flush.
    send_byte(8'h4D, 1'b0);
    send_byte(8'h61, 1'b0);
    send_byte(8'h6E, 1'b0);
    send_byte(8'h4D, 1'b1);
    // Five-byte message with alternating bit patterns.
    send_byte(8'hAA, 1'b0);
    send_byte(8'h55, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'hA5, 1'b1);
    drain_outputs();

    flood_while_blocked();

    // Random messages, mostly short so all end phases recur often.
    while (bytes_sent < NUM_BYTES) begin
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 48)
                                        : $urandom_range(1, 9);
      for (int i = 0; i < len; i++) begin
        case ($urandom_range(0, 7))
          0:       b = 8'h00;
          1:       b = 8'hFF;
          default: b = 8'($urandom);
        endcase
        send_byte(b, i == len - 1);
      end
      msg_cnt++;
      if (msg_cnt % 60 == 0) drain_outputs();
      if (msg_cnt % 90 == 0) flood_while_blocked();
    end

    // Wind down: wait for the last characters, then keep the clock running so any
    // stray extra output would still reach the monitor.
    in_ch.valid <= 1'b0;
    while (tracker.pending() != 0) @(negedge clk);
    repeat (10) @(negedge clk);

    if (tracker.errors == 0 && tracker.pending() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
